// ===== rtl/elrs_pkg.sv =====
// ----------------------------------------------------------------------------
// elrs_pkg
// Shared types and constants for the event log ring store.
// ----------------------------------------------------------------------------
package elrs_pkg;

   typedef enum logic [2:0] {
      REQ_APPEND  = 3'd0,
      REQ_PREPEND = 3'd1,
      REQ_CLEAR   = 3'd2,
      REQ_GET     = 3'd3,
      REQ_INFO    = 3'd4
   } req_code_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;
   localparam logic [1:0] ST_ABSENT   = 2'd3;

   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_GEN_TS   = 2'd1;
   localparam logic [1:0] CSR_OFFSET   = 2'd2;
   localparam logic [1:0] CSR_CAPACITY = 2'd3;

   localparam logic [31:0] NO_MORE_IDS  = 32'hFFFF_FFFE;
   localparam logic [31:0] NEWEST_ALIAS = 32'hFFFF_FFFF;
   localparam logic [31:0] OLDEST_ALIAS = 32'h0000_0000;
   localparam logic [63:0] TIME_UNSPEC  = 64'h8000_0000_0000_0000;
   localparam logic [31:0] NS_PER_SEC   = 32'd1_000_000_000;

   // command broadcast down the cell chain
   typedef struct packed {
      logic inc_all;   // renumber: every cell adds one to its id
      logic shift_in;  // prepend: cells shift one toward the tail
      logic clear;
   } chain_ctl_type;

endpackage

// ===== rtl/elrs_if.sv =====
// ----------------------------------------------------------------------------
// elrs_req_if / elrs_rsp_if / elrs_csr_if
// Valid/ready channels of the event log ring store.
// ----------------------------------------------------------------------------
interface elrs_req_if #(parameter int PAYLOAD_BITS = 64);
   logic                    valid;
   logic                    ready;
   logic [2:0]              req_type;
   logic [PAYLOAD_BITS-1:0] entry_payload;
   logic signed [63:0]      given_timestamp;
   logic [31:0]             query_id;
   logic [31:0]             now_seconds;
   modport source (output valid, req_type, entry_payload, given_timestamp, query_id,
                   now_seconds, input ready);
   modport sink (input valid, req_type, entry_payload, given_timestamp, query_id,
                 now_seconds, output ready);
endinterface

interface elrs_rsp_if #(parameter int PAYLOAD_BITS = 64);
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [31:0]             result_id;
   logic [PAYLOAD_BITS-1:0] result_payload;
   logic signed [63:0]      result_timestamp;
   logic [31:0]             prev_id;
   logic [31:0]             next_id_out;
   logic [6:0]              entry_count;
   logic signed [63:0]      last_update_time;
   logic signed [63:0]      current_time;
   modport source (output valid, status, result_id, result_payload, result_timestamp,
                   prev_id, next_id_out, entry_count, last_update_time, current_time,
                   input ready);
   modport sink (input valid, status, result_id, result_payload, result_timestamp,
                 prev_id, next_id_out, entry_count, last_update_time, current_time,
                 output ready);
endinterface

interface elrs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/event_log_ring_store.sv =====
// ----------------------------------------------------------------------------
// event_log_ring_store
// Bounded event log held in a chain of entry cells, oldest at cell zero.
// ----------------------------------------------------------------------------
// One request at a time. Info, clear, append and refused requests go through
// one multiply stage for the clock stamp, a decode and an output state. Append
// on a full log first shifts the chain one cell toward the head and decodes
// again. Prepend takes a renumber step and then a shift step. Get walks the
// chain one cell per cycle from the oldest; the walk through the cells sets
// the worst case.
module event_log_ring_store #(
   parameter int LOG_DEPTH    = 64,
   parameter int PAYLOAD_BITS = 64
) (
   input logic clock,
   input logic reset,
   elrs_req_if.sink   req,
   elrs_rsp_if.source rsp,
   elrs_csr_if.sink   csr
);
   localparam int IW = $clog2(LOG_DEPTH);
   localparam int CW = $clog2(LOG_DEPTH + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL   = 8'b0000_0010,
      S_DEC   = 8'b0000_0100,
      S_DROP  = 8'b0000_1000,
      S_RENUM = 8'b0001_0000,
      S_SHIFT = 8'b0010_0000,
      S_SCAN  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic                    en_ff, gen_ff;
   logic [63:0]             off_ff;
   logic [6:0]              cap_ff;

   logic [2:0]              rq_ff;
   logic [PAYLOAD_BITS-1:0] rpay_ff;
   logic [63:0]             rgts_ff;
   logic [31:0]             rq_id_ff, rsec_ff;
   logic [63:0]             prod_ff;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [31:0]             nid_ff, nid_in;
   logic [63:0]             lup_ff, lup_in;
   logic [IW-1:0]           scan_ff;
   logic [31:0]             tgt_ff;
   logic                    dropped_ff;
   logic [IW-1:0]           rd_idx_ff;
   logic [31:0]             rd_id_ff;
   logic [PAYLOAD_BITS-1:0] rd_pay_ff;
   logic [63:0]             rd_ts_ff;

   logic                    ov_ff;
   logic [1:0]              o_st_ff;
   logic [31:0]             o_id_ff, o_prev_ff, o_next_ff;
   logic [PAYLOAD_BITS-1:0] o_pay_ff;
   logic [63:0]             o_ts_ff, o_lup_ff, o_cur_ff;
   logic [6:0]              o_cnt_ff;

   logic [LOG_DEPTH-1:0]    c_vld;
   logic [31:0]             c_id  [LOG_DEPTH];
   logic [PAYLOAD_BITS-1:0] c_pay [LOG_DEPTH];
   logic [63:0]             c_ts  [LOG_DEPTH];
   logic [LOG_DEPTH-1:0]    c_load;
   elrs_pkg::chain_ctl_type ctl, ctl_drop;

   logic [CW-1:0] eff_cap;
   logic [63:0]   cur_time, stamp;
   logic [CW-1:0] last_idx;
   logic [31:0]   last_id;
   logic          need_drop;
   logic          fire;

   assign cur_time  = prod_ff + off_ff;
   assign stamp     = gen_ff ? cur_time : rgts_ff;
   assign last_idx  = cnt_ff - CW'(1);
   // newest id always trails the next id by one while the log is not empty
   assign last_id   = nid_ff - 32'd1;
   assign need_drop = (cnt_ff >= eff_cap) && (cnt_ff != '0) && !dropped_ff;

   always_comb begin
      if (cap_ff == 7'd0 || 32'(cap_ff) > LOG_DEPTH) begin
         eff_cap = CW'(LOG_DEPTH);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   // head-drop: shift chain toward cell zero through the cells' load path
   logic drop_now;
   assign drop_now = (state_ff == S_DROP);

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !ov_ff;
   assign fire      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= 1'b1;
         gen_ff <= 1'b1;
         off_ff <= '0;
         cap_ff <= 7'd64;
      end else if (csr.valid) begin
         unique case (csr.index)
            elrs_pkg::CSR_ENABLE:   en_ff  <= csr.data[0];
            elrs_pkg::CSR_GEN_TS:   gen_ff <= csr.data[0];
            elrs_pkg::CSR_OFFSET:   off_ff <= csr.data;
            elrs_pkg::CSR_CAPACITY: cap_ff <= csr.data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rq_ff    <= req.req_type;
         rpay_ff  <= req.entry_payload;
         rgts_ff  <= req.given_timestamp;
         rq_id_ff <= req.query_id;
         rsec_ff  <= req.now_seconds;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= 64'(rsec_ff) * 64'(elrs_pkg::NS_PER_SEC);
      end
   end

   // chain control
   always_comb begin
      ctl      = '0;
      ctl_drop = '0;
      c_load   = '0;
      ctl.clear    = (state_ff == S_DEC) && (rq_ff == elrs_pkg::REQ_CLEAR) && en_ff;
      ctl.inc_all  = (state_ff == S_RENUM);
      ctl.shift_in = (state_ff == S_SHIFT);
      if (state_ff == S_DEC && rq_ff == elrs_pkg::REQ_APPEND && en_ff && !need_drop) begin
         c_load[cnt_ff[IW-1:0]] = (cnt_ff < CW'(LOG_DEPTH));
      end
   end

   for (genvar g = 0; g < LOG_DEPTH; g++) begin : g_cell
      logic                    p_vld;
      logic [31:0]             p_id, n_id;
      logic [PAYLOAD_BITS-1:0] p_pay, n_pay;
      logic [63:0]             p_ts, n_ts;
      logic                    ld;
      elrs_pkg::chain_ctl_type cc;
      if (g == 0) begin : g_head
         assign p_vld = 1'b1;
         assign p_id  = 32'd1;
         assign p_pay = rpay_ff;
         assign p_ts  = stamp;
      end else begin : g_body
         assign p_vld = c_vld[g-1];
         assign p_id  = c_id[g-1];
         assign p_pay = c_pay[g-1];
         assign p_ts  = c_ts[g-1];
      end
      if (g == LOG_DEPTH - 1) begin : g_tail
         assign n_id  = '0;
         assign n_pay = '0;
         assign n_ts  = '0;
      end else begin : g_mid
         assign n_id  = c_id[g+1];
         assign n_pay = c_pay[g+1];
         assign n_ts  = c_ts[g+1];
      end
      // a drop reuses the load path with the contents of the next cell toward the tail
      always_comb begin
         cc = ctl;
         ld = c_load[g];
         if (drop_now) begin
            cc = ctl_drop;
            ld = 1'b1;
         end
      end
      elrs_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cc),
         .load     (ld),
         .prev_vld (p_vld),
         .prev_id  (p_id),
         .prev_pay (p_pay),
         .prev_ts  (p_ts),
         .new_id   (drop_now ? n_id  : nid_ff),
         .new_pay  (drop_now ? n_pay : rpay_ff),
         .new_ts   (drop_now ? n_ts  : stamp),
         .vld      (c_vld[g]),
         .id       (c_id[g]),
         .pay      (c_pay[g]),
         .ts       (c_ts[g])
      );
   end

   // control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      nid_in   = nid_ff;
      lup_in   = lup_ff;
      unique case (state_ff)
         S_IDLE:  if (fire) state_in = S_MUL;
         S_MUL:   state_in = S_DEC;
         S_DEC: begin
            state_in = S_OUT;
            if (rq_ff <= elrs_pkg::REQ_CLEAR && en_ff) begin
               unique case (rq_ff)
                  elrs_pkg::REQ_APPEND: begin
                     if (need_drop) begin
                        state_in = S_DROP;
                     end else begin
                        cnt_in = cnt_ff + CW'(1);
                        nid_in = nid_ff + 32'd1;
                        lup_in = stamp;
                     end
                  end
                  elrs_pkg::REQ_PREPEND: begin
                     if (cnt_ff < eff_cap) begin
                        state_in = S_RENUM;
                     end
                  end
                  default: begin
                     cnt_in = '0;
                     nid_in = 32'd1;
                     lup_in = elrs_pkg::TIME_UNSPEC;
                  end
               endcase
            end else if (rq_ff == elrs_pkg::REQ_GET && cnt_ff != '0) begin
               state_in = S_SCAN;
            end
         end
         S_DROP: begin
            cnt_in   = cnt_ff - CW'(1);
            state_in = S_DEC;
         end
         S_RENUM: state_in = S_SHIFT;
         S_SHIFT: begin
            cnt_in   = cnt_ff + CW'(1);
            nid_in   = nid_ff + 32'd1;
            lup_in   = stamp;
            state_in = S_OUT;
         end
         S_SCAN: begin
            if (rd_id_ff == tgt_ff || rq_id_ff < rd_id_ff
                || CW'(rd_idx_ff) == last_idx) begin
               state_in = S_OUT;
            end
         end
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         nid_ff     <= 32'd1;
         lup_ff     <= elrs_pkg::TIME_UNSPEC;
         ov_ff      <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         nid_ff   <= nid_in;
         lup_ff   <= lup_in;
         if (state_ff == S_OUT) begin
            ov_ff <= 1'b1;
         end else if (rsp.ready) begin
            ov_ff <= 1'b0;
         end
         if (state_ff == S_DROP) begin
            dropped_ff <= 1'b1;
         end else if (state_ff == S_IDLE) begin
            dropped_ff <= 1'b0;
         end
      end
   end

   // result assembly
   always_ff @(posedge clock) begin
      if (state_ff == S_DEC) begin
         scan_ff   <= IW'(1);
         rd_idx_ff <= '0;
         rd_id_ff  <= c_id[0];
         rd_pay_ff <= c_pay[0];
         rd_ts_ff  <= c_ts[0];
         tgt_ff   <= (rq_id_ff == elrs_pkg::NEWEST_ALIAS) ? last_id :
                     (rq_id_ff == elrs_pkg::OLDEST_ALIAS) ? c_id[0] : rq_id_ff;
         o_st_ff  <= elrs_pkg::ST_OK;
         o_id_ff  <= '0;
         o_pay_ff <= '0;
         o_ts_ff  <= '0;
         o_prev_ff <= '0;
         o_next_ff <= '0;
         o_cnt_ff <= '0;
         o_lup_ff <= '0;
         o_cur_ff <= '0;
         if (rq_ff <= elrs_pkg::REQ_CLEAR && !en_ff) begin
            o_st_ff <= elrs_pkg::ST_INVALID;
         end else begin
            unique case (rq_ff)
               elrs_pkg::REQ_APPEND: begin
                  o_id_ff <= nid_ff;
                  o_ts_ff <= stamp;
               end
               elrs_pkg::REQ_PREPEND: begin
                  if (cnt_ff >= eff_cap) begin
                     o_st_ff <= elrs_pkg::ST_NO_SPACE;
                  end else begin
                     o_id_ff <= 32'd1;
                     o_ts_ff <= stamp;
                  end
               end
               elrs_pkg::REQ_CLEAR: ;
               elrs_pkg::REQ_GET: o_st_ff <= elrs_pkg::ST_ABSENT;
               elrs_pkg::REQ_INFO: begin
                  o_cnt_ff <= 7'(cnt_ff);
                  o_lup_ff <= lup_ff;
                  o_cur_ff <= cur_time;
               end
               default: o_st_ff <= elrs_pkg::ST_INVALID;
            endcase
         end
      end else if (state_ff == S_SCAN) begin
         scan_ff   <= scan_ff + IW'(1);
         rd_idx_ff <= scan_ff;
         rd_id_ff  <= c_id[scan_ff];
         rd_pay_ff <= c_pay[scan_ff];
         rd_ts_ff  <= c_ts[scan_ff];
         if (rd_id_ff == tgt_ff) begin
            o_st_ff  <= elrs_pkg::ST_OK;
            o_id_ff  <= rd_id_ff;
            o_pay_ff <= rd_pay_ff;
            o_ts_ff  <= rd_ts_ff;
            o_prev_ff <= (rd_id_ff == c_id[0]) ? elrs_pkg::NO_MORE_IDS :
                         rd_id_ff - 32'd1;
            o_next_ff <= (rd_id_ff == last_id) ? elrs_pkg::NO_MORE_IDS :
                         rd_id_ff + 32'd1;
         end
      end
   end

   assign rsp.valid            = ov_ff;
   assign rsp.status           = o_st_ff;
   assign rsp.result_id        = o_id_ff;
   assign rsp.result_payload   = o_pay_ff;
   assign rsp.result_timestamp = o_ts_ff;
   assign rsp.prev_id          = o_prev_ff;
   assign rsp.next_id_out      = o_next_ff;
   assign rsp.entry_count      = o_cnt_ff;
   assign rsp.last_update_time = o_lup_ff;
   assign rsp.current_time     = o_cur_ff;
endmodule

// ===== rtl/elrs_cell.sv =====
// ----------------------------------------------------------------------------
// elrs_cell
// One log entry slot; shifts toward the tail on prepend, renumbers in place.
// ----------------------------------------------------------------------------
module elrs_cell #(
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  elrs_pkg::chain_ctl_type   ctl,
   input  logic                      load,      // append or head-drop write into this cell
   input  logic                      prev_vld,
   input  logic [31:0]               prev_id,
   input  logic [PAYLOAD_BITS-1:0]   prev_pay,
   input  logic [63:0]               prev_ts,
   input  logic [31:0]               new_id,
   input  logic [PAYLOAD_BITS-1:0]   new_pay,
   input  logic [63:0]               new_ts,
   output logic                      vld,
   output logic [31:0]               id,
   output logic [PAYLOAD_BITS-1:0]   pay,
   output logic [63:0]               ts
);
   logic                    vld_ff, vld_in;
   logic [31:0]             id_ff, id_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [63:0]             ts_ff, ts_in;

   always_comb begin
      vld_in = vld_ff;
      id_in  = id_ff;
      pay_in = pay_ff;
      ts_in  = ts_ff;
      priority if (ctl.clear) begin
         vld_in = 1'b0;
      end else if (ctl.shift_in) begin
         vld_in = prev_vld;
         id_in  = prev_id;
         pay_in = prev_pay;
         ts_in  = prev_ts;
      end else if (ctl.inc_all) begin
         id_in = id_ff + 32'd1;
      end else if (load) begin
         vld_in = 1'b1;
         id_in  = new_id;
         pay_in = new_pay;
         ts_in  = new_ts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      id_ff  <= id_in;
      pay_ff <= pay_in;
      ts_ff  <= ts_in;
   end

   assign vld = vld_ff;
   assign id  = id_ff;
   assign pay = pay_ff;
   assign ts  = ts_ff;
endmodule

// ===== rtl/elrs_checker.sv =====
// ----------------------------------------------------------------------------
// elrs_checker
// Port-level checks of the event log ring store.
// ----------------------------------------------------------------------------
module elrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [6:0] rsp_entry_count
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while a beat is pending");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("back to back accept");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= 7'd64) else $error("count out of range");
endmodule

bind event_log_ring_store elrs_checker u_elrs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_entry_count (rsp.entry_count)
);

// ===== sim/elrs_scoreboard.sv =====
// ----------------------------------------------------------------------------
// elrs_scoreboard_pkg
// Tracks the event log the block should hold and checks every response beat.
// ----------------------------------------------------------------------------
package elrs_scoreboard_pkg;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        result_id;
      logic [63:0]        result_payload;
      logic signed [63:0] result_timestamp;
      logic [31:0]        prev_id;
      logic [31:0]        next_id_out;
      logic [6:0]         entry_count;
      logic signed [63:0] last_update_time;
      logic signed [63:0] current_time;
   } rsp_beat_type;

   class elrs_scoreboard;
      localparam int DEPTH = 64;

      logic [63:0]  pay_mem [DEPTH];
      logic [31:0]  id_mem [DEPTH];
      logic [63:0]  ts_mem [DEPTH];
      int unsigned  head;
      int unsigned  count;
      logic [31:0]  next_id;
      logic [63:0]  last_upd;
      bit           enabled;
      bit           gen_ts;
      logic [63:0]  offset;
      logic [6:0]   capacity;
      rsp_beat_type pending[$];
      int           errors;
      int           checked;

      function new();
         head = 0; count = 0; next_id = 1; last_upd = elrs_pkg::TIME_UNSPEC;
         enabled = 1; gen_ts = 1; offset = 0; capacity = 64;
         errors = 0; checked = 0;
      endfunction

      function void write_csr(logic [1:0] idx, logic [63:0] data);
         case (idx)
            elrs_pkg::CSR_ENABLE:   enabled = data[0];
            elrs_pkg::CSR_GEN_TS:   gen_ts = data[0];
            elrs_pkg::CSR_OFFSET:   offset = data;
            elrs_pkg::CSR_CAPACITY: capacity = data[6:0];
            default: ;
         endcase
      endfunction

      function int unsigned cap_eff();
         if (capacity == 0 || capacity > DEPTH) return DEPTH;
         return capacity;
      endfunction

      function logic [63:0] clock_ts(logic [31:0] secs);
         return 64'(secs) * 64'd1000000000 + offset;
      endfunction

      function int unsigned at(int unsigned k);
         return (head + k) % DEPTH;
      endfunction

      function void note_request(logic [2:0] rt, logic [63:0] pay, logic [63:0] gts,
                                 logic [31:0] qid, logic [31:0] secs);
         rsp_beat_type e;
         logic [63:0]  t;
         logic [31:0]  first_id, last_id, target, id;
         int unsigned  p;
         e = '0;
         t = gen_ts ? clock_ts(secs) : gts;
         if (rt <= 3'd2 && !enabled) begin
            e.status = elrs_pkg::ST_INVALID;
         end else begin
            case (rt)
               elrs_pkg::REQ_APPEND: begin
                  if (count >= cap_eff() && count > 0) begin
                     head = at(1); count--;
                  end
                  p = at(count);
                  last_upd = t;
                  pay_mem[p] = pay; id_mem[p] = next_id; ts_mem[p] = t;
                  count++;
                  e.result_id = next_id; e.result_timestamp = t;
                  next_id++;
               end
               elrs_pkg::REQ_PREPEND: begin
                  if (count >= cap_eff()) begin
                     e.status = elrs_pkg::ST_NO_SPACE;
                  end else begin
                     for (int unsigned k = 0; k < count; k++) id_mem[at(k)]++;
                     head = (head + DEPTH - 1) % DEPTH;
                     last_upd = t;
                     pay_mem[head] = pay; id_mem[head] = 1; ts_mem[head] = t;
                     count++; next_id++;
                     e.result_id = 1; e.result_timestamp = t;
                  end
               end
               elrs_pkg::REQ_CLEAR: begin
                  head = 0; count = 0; next_id = 1; last_upd = elrs_pkg::TIME_UNSPEC;
               end
               elrs_pkg::REQ_GET: begin
                  e.status = elrs_pkg::ST_ABSENT;
                  if (count > 0) begin
                     first_id = id_mem[at(0)];
                     last_id = id_mem[at(count - 1)];
                     target = (qid == elrs_pkg::NEWEST_ALIAS) ? last_id :
                              (qid == elrs_pkg::OLDEST_ALIAS) ? first_id : qid;
                     for (int unsigned k = 0; k < count; k++) begin
                        p = at(k);
                        id = id_mem[p];
                        if (id == target) begin
                           e.status = elrs_pkg::ST_OK; e.result_id = id;
                           e.result_payload = pay_mem[p]; e.result_timestamp = ts_mem[p];
                           e.prev_id = (id == first_id) ? elrs_pkg::NO_MORE_IDS : id - 1;
                           e.next_id_out = (id == last_id) ? elrs_pkg::NO_MORE_IDS : id + 1;
                           break;
                        end
                        if (qid < id) break;
                     end
                  end
               end
               elrs_pkg::REQ_INFO: begin
                  e.entry_count = count[6:0];
                  e.last_update_time = last_upd;
                  e.current_time = clock_ts(secs);
               end
               default: e.status = elrs_pkg::ST_INVALID;
            endcase
         end
         pending.push_back(e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch beat %0d %s: got %h want %h", checked, what, got, want);
      endtask

      task check_response(rsp_beat_type got);
         rsp_beat_type w;
         if (pending.size() == 0) begin
            report("unexpected beat", '0, '0);
         end else begin
            w = pending.pop_front();
            if (got.status !== w.status) report("status", got.status, w.status);
            if (got.result_id !== w.result_id) report("result_id", got.result_id, w.result_id);
            if (got.result_payload !== w.result_payload)
               report("result_payload", got.result_payload, w.result_payload);
            if (got.result_timestamp !== w.result_timestamp)
               report("result_timestamp", got.result_timestamp, w.result_timestamp);
            if (got.prev_id !== w.prev_id) report("prev_id", got.prev_id, w.prev_id);
            if (got.next_id_out !== w.next_id_out)
               report("next_id_out", got.next_id_out, w.next_id_out);
            if (got.entry_count !== w.entry_count)
               report("entry_count", got.entry_count, w.entry_count);
            if (got.last_update_time !== w.last_update_time)
               report("last_update_time", got.last_update_time, w.last_update_time);
            if (got.current_time !== w.current_time)
               report("current_time", got.current_time, w.current_time);
         end
         checked++;
      endtask
   endclass

endpackage

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Event log ring store regression: directed corner requests, then random traffic
// of all request codes over several register settings, with random stalls on the
// request and response channels, checked beat by beat against a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 20000;

   logic clock;
   logic reset;
   elrs_req_if req_if ();
   elrs_rsp_if rsp_if ();
   elrs_csr_if csr_if ();

   event_log_ring_store u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   elrs_scoreboard_pkg::elrs_scoreboard log_sb;
   int  idle_cycles;
   int  req_count;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      log_sb = new();
      reset = 1;
      req_if.valid = 0; req_if.req_type = '0; req_if.entry_payload = '0;
      req_if.given_timestamp = '0; req_if.query_id = '0; req_if.now_seconds = '0;
      csr_if.valid = 0; csr_if.index = '0; csr_if.data = '0;
      rsp_if.ready = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   // response side
   initial begin
      int gap;
      elrs_scoreboard_pkg::rsp_beat_type b;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, 13);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_if.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1;
         do @(posedge clock); while (!rsp_if.valid);
         b = '{rsp_if.status, rsp_if.result_id, 64'(rsp_if.result_payload),
               rsp_if.result_timestamp, rsp_if.prev_id, rsp_if.next_id_out,
               rsp_if.entry_count, rsp_if.last_update_time, rsp_if.current_time};
         log_sb.check_response(b);
         idle_cycles = 0;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            log_sb.note_request(req_if.req_type, 64'(req_if.entry_payload),
                                req_if.given_timestamp, req_if.query_id,
                                req_if.now_seconds);
            idle_cycles = 0;
         end else if (csr_if.valid && csr_if.ready) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] data);
      csr_if.valid <= 1; csr_if.index <= idx; csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      log_sb.write_csr(idx, data);
      @(negedge clock);
      csr_if.valid <= 0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (log_sb.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic send_req(logic [2:0] rt, logic [63:0] pay, logic [63:0] gts,
                           logic [31:0] qid, logic [31:0] secs);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1; req_if.req_type <= rt; req_if.entry_payload <= pay;
      req_if.given_timestamp <= gts; req_if.query_id <= qid; req_if.now_seconds <= secs;
      do @(posedge clock); while (!req_if.ready);
      req_count++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_if.valid <= 0;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] rnd_query();
      int unsigned n;
      n = log_sb.next_id;
      case ($urandom_range(0, 5))
         0: return elrs_pkg::OLDEST_ALIAS;
         1: return elrs_pkg::NEWEST_ALIAS;
         2: return $urandom;
         default: return n - $urandom_range(0, 70);
      endcase
   endfunction

   task automatic random_phase(int n);
      int unsigned r;
      logic [2:0] rt;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) rt = elrs_pkg::REQ_APPEND;
         else if (r < 50) rt = elrs_pkg::REQ_PREPEND;
         else if (r < 80) rt = elrs_pkg::REQ_GET;
         else if (r < 92) rt = elrs_pkg::REQ_INFO;
         else if (r < 96) rt = elrs_pkg::REQ_CLEAR;
         else rt = 3'($urandom_range(5, 7));
         send_req(rt, rnd64(), rnd64(), rnd_query(), $urandom);
      end
      end_burst();
      wait_idle();
   endtask

   initial begin
      req_count = 0; idle_cycles = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (80) @(negedge clock);

      // directed
      send_req(elrs_pkg::REQ_INFO, '0, '0, '0, '0);
      send_req(elrs_pkg::REQ_GET, '0, '0, elrs_pkg::OLDEST_ALIAS, '0);
      send_req(elrs_pkg::REQ_APPEND, '1, '0, '0, 32'hFFFF_FFFF);
      send_req(elrs_pkg::REQ_APPEND, '0, '1, '0, '0);
      send_req(elrs_pkg::REQ_PREPEND, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
               '0, 32'd7);
      send_req(elrs_pkg::REQ_GET, '0, '0, elrs_pkg::OLDEST_ALIAS, '0);
      send_req(elrs_pkg::REQ_GET, '0, '0, elrs_pkg::NEWEST_ALIAS, '0);
      send_req(elrs_pkg::REQ_GET, '0, '0, 32'd2, '0);
      send_req(elrs_pkg::REQ_GET, '0, '0, 32'd99, '0);
      send_req(3'd5, '0, '0, '0, '0);
      send_req(3'd7, '1, '1, '1, '1);
      send_req(elrs_pkg::REQ_INFO, '0, '0, '0, 32'hFFFF_FFFF);
      send_req(elrs_pkg::REQ_CLEAR, '0, '0, '0, '0);
      send_req(elrs_pkg::REQ_INFO, '0, '0, '0, 32'd1);
      end_burst();
      wait_idle();

      write_reg(elrs_pkg::CSR_ENABLE, 64'd0);
      write_reg(elrs_pkg::CSR_GEN_TS, 64'd0);
      write_reg(elrs_pkg::CSR_OFFSET, 64'h8000_0000_0000_0000);
      write_reg(elrs_pkg::CSR_CAPACITY, 64'd1);
      send_req(elrs_pkg::REQ_APPEND, '1, '1, '0, '0);
      send_req(elrs_pkg::REQ_PREPEND, '1, '1, '0, '0);
      send_req(elrs_pkg::REQ_CLEAR, '0, '0, '0, '0);
      send_req(elrs_pkg::REQ_INFO, '0, '0, '0, 32'hFFFF_FFFF);
      end_burst();
      wait_idle();
      write_reg(elrs_pkg::CSR_ENABLE, 64'd1);
      send_req(elrs_pkg::REQ_APPEND, 64'h1234, 64'h8000_0000_0000_0000, '0, '0);
      send_req(elrs_pkg::REQ_APPEND, 64'h5678, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
      send_req(elrs_pkg::REQ_PREPEND, '0, '0, '0, '0);
      send_req(elrs_pkg::REQ_GET, '0, '0, elrs_pkg::NEWEST_ALIAS, '0);
      end_burst();
      wait_idle();

      // random phases over settings
      write_reg(elrs_pkg::CSR_CAPACITY, 64'd4);
      write_reg(elrs_pkg::CSR_OFFSET, rnd64());
      random_phase(150);
      write_reg(elrs_pkg::CSR_GEN_TS, 64'd1);
      write_reg(elrs_pkg::CSR_CAPACITY, 64'd64);
      random_phase(200);
      write_reg(elrs_pkg::CSR_CAPACITY, 64'd0);
      write_reg(elrs_pkg::CSR_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
      random_phase(120);
      write_reg(elrs_pkg::CSR_CAPACITY, 64'd2);
      write_reg(elrs_pkg::CSR_GEN_TS, 64'd0);
      random_phase(100);
      write_reg(elrs_pkg::CSR_CAPACITY, 64'd100);
      write_reg(elrs_pkg::CSR_ENABLE, 64'd0);
      random_phase(40);
      write_reg(elrs_pkg::CSR_ENABLE, 64'd1);
      write_reg(elrs_pkg::CSR_CAPACITY, 64'($urandom_range(1, 64)));
      random_phase(140);

      $display("covered %0d requests, %0d response beats, capacities 0..100",
               req_count, log_sb.checked);
      if (log_sb.errors == 0 && log_sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d errors, %0d responses missing", log_sb.errors,
                  log_sb.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
